/* hdl/dsu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dsu_pkg;

  localparam int ELEM_W        = 10;
  localparam int CNT_W         = 11;
  localparam int SIZE_W        = 11;
  localparam int MAX_ELEMS_DEF = 1024;
  localparam int COUNT_RESET   = 1024;

  typedef enum logic {
    REQ_UNION = 1'b0,
    REQ_CLEAR = 1'b1
  } req_t;

endpackage

`default_nettype wire

/* hdl/dsu_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dsu_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hdl/dsu_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module dsu_seq #(
  parameter int MAX_ELEMS = dsu_pkg::MAX_ELEMS_DEF,
  localparam int IDX_W    = $clog2(MAX_ELEMS),
  localparam int ENT_W    = dsu_pkg::SIZE_W + IDX_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [dsu_pkg::CNT_W-1:0]   element_count,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        req_type,
  input  wire logic [dsu_pkg::ELEM_W-1:0]  elem_a,
  input  wire logic [dsu_pkg::ELEM_W-1:0]  elem_b,
  output logic                             done,
  output logic      [dsu_pkg::ELEM_W-1:0]  set_root,
  output logic      [dsu_pkg::SIZE_W-1:0]  set_size,
  output logic                             merged,
  output logic                             range_error,
  output logic                             ram_wr_en,
  output logic      [IDX_W-1:0]            ram_wr_addr,
  output logic      [ENT_W-1:0]            ram_wr_data,
  output logic      [IDX_W-1:0]            ram_rd_addr,
  input  wire logic [ENT_W-1:0]            ram_rd_data
);

  localparam int SIZE_W = dsu_pkg::SIZE_W;
  localparam int CMP_W  = (IDX_W + 1 > dsu_pkg::CNT_W) ? IDX_W + 1 : dsu_pkg::CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ELEMS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_COMP,
    S_LINK,
    S_FIX
  } state_t;

  state_t              state;
  logic                phase_b;
  logic                clr_rep;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    node;
  logic [IDX_W-1:0]    xstart;
  logic [IDX_W-1:0]    b_reg;
  logic [IDX_W-1:0]    rootr;
  logic [SIZE_W-1:0]   rsz;
  logic [IDX_W-1:0]    ra;
  logic [SIZE_W-1:0]   sa;
  logic [IDX_W-1:0]    rb;
  logic [SIZE_W-1:0]   sb;
  logic [IDX_W-1:0]    lk_root;
  logic [SIZE_W-1:0]   lk_sum;

  logic [IDX_W-1:0]    par;
  logic [SIZE_W-1:0]   sz;
  logic                walk_found;
  logic                phase_done;
  logic [IDX_W-1:0]    done_root;
  logic [SIZE_W-1:0]   done_size;
  logic                range_bad;
  logic [CMP_W-1:0]    a_ext;
  logic [CMP_W-1:0]    b_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic                b_bigger;
  logic [IDX_W-1:0]    big_root;
  logic [IDX_W-1:0]    small_root;

  assign par = ram_rd_data[IDX_W-1:0];
  assign sz  = ram_rd_data[IDX_W +: SIZE_W];

  assign a_ext     = CMP_W'(elem_a);
  assign b_ext     = CMP_W'(elem_b);
  assign cnt_ext   = CMP_W'(element_count);
  assign range_bad = (a_ext >= cnt_ext) || (a_ext >= CMP_W'(MAX_ELEMS)) ||
                     (b_ext >= cnt_ext) || (b_ext >= CMP_W'(MAX_ELEMS));

  // a root points at itself; compression ends when the next hop is the root
  assign walk_found = (state == S_WALK) && (par == node);
  assign phase_done = (walk_found && (xstart == node)) ||
                      ((state == S_COMP) && (par == rootr));
  assign done_root  = (state == S_WALK) ? node : rootr;
  assign done_size  = (state == S_WALK) ? sz : rsz;

  // tie keeps a's root on top
  assign b_bigger   = sa < sb;
  assign big_root   = b_bigger ? rb : ra;
  assign small_root = b_bigger ? ra : rb;

  assign busy = (state != S_IDLE);

  always_comb begin
    ram_rd_addr = node;
    if (state == S_IDLE) begin
      ram_rd_addr = IDX_W'(elem_a);
    end else if (phase_done && !phase_b) begin
      ram_rd_addr = b_reg;
    end else if (walk_found) begin
      ram_rd_addr = xstart;
    end else if ((state == S_WALK) || (state == S_COMP)) begin
      ram_rd_addr = par;
    end
  end

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = node;
    ram_wr_data = {rsz, rootr};
    unique case (state)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx;
        ram_wr_data = {SIZE_W'(1), idx};
      end
      S_COMP: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = node;
        ram_wr_data = {rsz, rootr};
      end
      S_LINK: begin
        ram_wr_en   = (ra != rb);
        ram_wr_addr = small_root;
        ram_wr_data = {sb, big_root};
      end
      S_FIX: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = lk_root;
        ram_wr_data = {lk_sum, lk_root};
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      idx         <= '0;
      clr_rep     <= 1'b0;
      phase_b     <= 1'b0;
      done        <= 1'b0;
      set_root    <= '0;
      set_size    <= '0;
      merged      <= 1'b0;
      range_error <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          idx <= idx + IDX_W'(1);
          if (idx == LAST_IDX) begin
            state       <= S_IDLE;
            done        <= clr_rep;
            set_root    <= '0;
            set_size    <= '0;
            merged      <= 1'b0;
            range_error <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (req_type == dsu_pkg::REQ_CLEAR) begin
              state   <= S_CLEAR;
              idx     <= '0;
              clr_rep <= 1'b1;
            end else if (range_bad) begin
              done        <= 1'b1;
              set_root    <= '0;
              set_size    <= '0;
              merged      <= 1'b0;
              range_error <= 1'b1;
            end else begin
              state   <= S_WALK;
              phase_b <= 1'b0;
              node    <= IDX_W'(elem_a);
              xstart  <= IDX_W'(elem_a);
              b_reg   <= IDX_W'(elem_b);
            end
          end
        end
        S_WALK, S_COMP: begin
          if (phase_done) begin
            if (!phase_b) begin
              ra      <= done_root;
              sa      <= done_size;
              phase_b <= 1'b1;
              node    <= b_reg;
              xstart  <= b_reg;
              state   <= S_WALK;
            end else begin
              rb    <= done_root;
              sb    <= done_size;
              state <= S_LINK;
            end
          end else if (walk_found) begin
            // root found, go back over the path from the start
            rootr <= node;
            rsz   <= sz;
            node  <= xstart;
            state <= S_COMP;
          end else begin
            node <= par;
          end
        end
        S_LINK: begin
          if (ra == rb) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            set_root    <= dsu_pkg::ELEM_W'(ra);
            set_size    <= sa;
            merged      <= 1'b0;
            range_error <= 1'b0;
          end else begin
            lk_root <= big_root;
            lk_sum  <= sa + sb;
            state   <= S_FIX;
          end
        end
        S_FIX: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          set_root    <= dsu_pkg::ELEM_W'(lk_root);
          set_size    <= lk_sum;
          merged      <= 1'b1;
          range_error <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/disjoint_set_union_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// disjoint-set engine: union by size with path compression over one table
// memory holding {set size, parent} per element.
// command channel: a word is taken on a clock edge with start high and busy
// low. req_type selects a union of elem_a and elem_b or a clear of all sets.
// each command gives exactly one result word, shown for one cycle with done
// high; the receiver cannot stall, so it must take the word that cycle.
// a range error is answered straight from idle, without a table walk. a union
// walks the parent chain of elem_a and then that of elem_b; a step is one hop
// up a parent chain, read on the way up and rewritten on the way back. a union
// of two elements already in one set then ends; when the sets are merged, the
// small root is relinked and the new root's size is rewritten. a clear sweeps
// the whole table. one command is in flight at a time.
// element_count is written by cfg_wr_en / cfg_wr_data; the user writes it only
// while the block is idle, which the block itself does not enforce. it resets to 1024.
// reset: a clearing pass over all MAX_ELEMS entries runs with busy high and no
// result word; configuration writes are taken during it.
module disjoint_set_union_engine #(
  parameter int MAX_ELEMS = dsu_pkg::MAX_ELEMS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        req_type,
  input  wire logic [dsu_pkg::ELEM_W-1:0]  elem_a,
  input  wire logic [dsu_pkg::ELEM_W-1:0]  elem_b,
  input  wire logic                        cfg_wr_en,
  input  wire logic [dsu_pkg::CNT_W-1:0]   cfg_wr_data,
  output logic                             done,
  output logic      [dsu_pkg::ELEM_W-1:0]  set_root,
  output logic      [dsu_pkg::SIZE_W-1:0]  set_size,
  output logic                             merged,
  output logic                             range_error
);

  localparam int IDX_W = $clog2(MAX_ELEMS);
  localparam int ENT_W = dsu_pkg::SIZE_W + IDX_W;

  logic [dsu_pkg::CNT_W-1:0] element_count;
  logic                      ram_wr_en;
  logic [IDX_W-1:0]          ram_wr_addr;
  logic [ENT_W-1:0]          ram_wr_data;
  logic [IDX_W-1:0]          ram_rd_addr;
  logic [ENT_W-1:0]          ram_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= dsu_pkg::CNT_W'(dsu_pkg::COUNT_RESET);
    end else if (cfg_wr_en) begin
      element_count <= cfg_wr_data;
    end
  end

  dsu_seq #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .element_count(element_count),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .elem_a       (elem_a),
    .elem_b       (elem_b),
    .done         (done),
    .set_root     (set_root),
    .set_size     (set_size),
    .merged       (merged),
    .range_error  (range_error),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data)
  );

  dsu_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_ELEMS)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

endmodule

`default_nettype wire

/* sim/disjoint_set_union_engine_tb.sv */
`timescale 1ns / 1ps

module disjoint_set_union_engine_tb;
  import dsu_pkg::*;

  localparam int ELEMS       = MAX_ELEMS_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int NUM_PHASES  = 12;

  typedef struct packed {
    logic [ELEM_W-1:0] root;
    logic [SIZE_W-1:0] size;
    logic              merged;
    logic              range_err;
  } union_result_t;

  class dsu_scoreboard;
    logic [ELEM_W-1:0] parent_tbl [ELEMS];
    logic [SIZE_W-1:0] size_tbl   [ELEMS];
    logic [CNT_W-1:0]  elem_count;
    union_result_t     expected_q [$];
    int                errors;

    function new();
      elem_count = CNT_W'(COUNT_RESET);
      errors     = 0;
      clear_sets();
    endfunction

    function void clear_sets();
      for (int i = 0; i < ELEMS; i++) begin
        parent_tbl[i] = ELEM_W'(i);
        size_tbl[i]   = SIZE_W'(1);
      end
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      elem_count = v;
    endfunction

    function int unsigned usable_count();
      return (elem_count > ELEMS) ? ELEMS : elem_count;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // walk to the root, then point every element on the path straight at it
    function logic [ELEM_W-1:0] root_with_compress(logic [ELEM_W-1:0] x);
      logic [ELEM_W-1:0] r, cur, nxt;
      int                steps;
      r = x;
      steps = 0;
      while (parent_tbl[r] != r && steps < ELEMS) begin
        r = parent_tbl[r];
        steps++;
      end
      cur = x;
      steps = 0;
      while (cur != r && steps < ELEMS) begin
        nxt = parent_tbl[cur];
        parent_tbl[cur] = r;
        cur = nxt;
        steps++;
      end
      return r;
    endfunction

    function void note_request(req_t kind, logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
      union_result_t     e;
      int unsigned       lim;
      logic [ELEM_W-1:0] ra, rb, top;
      e   = '0;
      lim = usable_count();
      if (kind == REQ_CLEAR) begin
        clear_sets();
      end else if (a >= lim || b >= lim) begin
        e.range_err = 1'b1;
      end else begin
        ra  = root_with_compress(a);
        rb  = root_with_compress(b);
        top = ra;
        if (ra != rb) begin
          // smaller set goes under the larger, a tie keeps elem_a's root
          if (size_tbl[ra] < size_tbl[rb]) begin
            top = rb;
            rb  = ra;
          end
          parent_tbl[rb] = top;
          size_tbl[top]  = size_tbl[top] + size_tbl[rb];
          e.merged = 1'b1;
        end
        e.root = top;
        e.size = size_tbl[top];
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(logic [ELEM_W-1:0] root, logic [SIZE_W-1:0] size,
                               logic merged, logic range_err);
      union_result_t e;
      if (expected_q.size() == 0) begin
        $error("result word with nothing pending: root %0d size %0d", root, size);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (root !== e.root) begin
        $error("set_root: expected %0d, got %0d", e.root, root);
        errors++;
      end
      if (size !== e.size) begin
        $error("set_size: expected %0d, got %0d", e.size, size);
        errors++;
      end
      if (merged !== e.merged) begin
        $error("merged: expected %0d, got %0d", e.merged, merged);
        errors++;
      end
      if (range_err !== e.range_err) begin
        $error("range_error: expected %0d, got %0d", e.range_err, range_err);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              req_type;
  logic [ELEM_W-1:0] elem_a;
  logic [ELEM_W-1:0] elem_b;
  logic              cfg_wr_en;
  logic [CNT_W-1:0]  cfg_wr_data;
  logic              done;
  logic [ELEM_W-1:0] set_root;
  logic [SIZE_W-1:0] set_size;
  logic              merged;
  logic              range_error;

  dsu_scoreboard sb;
  bit            idle_on;
  int            stall_cycles;

  disjoint_set_union_engine dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .elem_a      (elem_a),
    .elem_b      (elem_b),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .set_root    (set_root),
    .set_size    (set_size),
    .merged      (merged),
    .range_error (range_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      sb.check_result(set_root, set_size, merged, range_error);
    end
  end

  always @(posedge clk) begin
    if (rst || done === 1'b1 || (start && busy === 1'b0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[disjoint_set_union_engine] ERROR");
      $finish;
    end
  end

  // entered and left at a falling edge; start stays high after the word is taken
  task automatic send_request(req_t kind, logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      start    <= 1'b0;
      req_type <= 1'($urandom);
      elem_a   <= ELEM_W'($urandom);
      elem_b   <= ELEM_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    req_type <= kind;
    elem_a   <= a;
    elem_b   <= b;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(kind, a, b);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0 || busy !== 1'b0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_element_count(logic [CNT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    sb.set_count(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_request();
    int unsigned       lim, pick, span;
    logic [ELEM_W-1:0] a, b;
    lim  = sb.usable_count();
    pick = $urandom_range(0, 99);
    a    = ELEM_W'($urandom);
    b    = ELEM_W'($urandom);
    if (pick < 2) begin
      send_request(REQ_CLEAR, a, b);
      return;
    end
    if (lim > 0 && pick >= 8) begin
      // a narrow window half the time so sets grow large
      span = (lim > 48 && $urandom_range(0, 1) == 1) ? 48 : lim;
      a = ELEM_W'($urandom_range(0, span - 1));
      b = (pick < 20) ? a : ELEM_W'($urandom_range(0, span - 1));
    end else if (lim > 0 && lim < ELEMS) begin
      if (pick[0]) a = ELEM_W'($urandom_range(lim, ELEMS - 1));
      else         b = ELEM_W'($urandom_range(lim, ELEMS - 1));
    end
    send_request(REQ_UNION, a, b);
  endtask

  initial begin
    int unsigned phase_count [NUM_PHASES];
    int          phase_items [NUM_PHASES];
    rst         = 1'b1;
    start       = 1'b0;
    req_type    = REQ_UNION;
    elem_a      = '0;
    elem_b      = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    sb          = new();
    idle_on     = 1'b1;
    phase_count = '{1024, 2, 64, 0, 2047, 16, 1025, 700, 1, 128, 1024, 1024};
    phase_items = '{145, 140, 145, 20, 145, 140, 145, 145, 30, 145, 145, 145};
    phase_count[NUM_PHASES-1] = $urandom_range(1, 1024);
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: self query, ties, larger set wins, same set, clear
    send_request(REQ_UNION, 10'd0, 10'd0);
    send_request(REQ_UNION, 10'd1023, 10'd1023);
    send_request(REQ_UNION, 10'd0, 10'd1023);
    send_request(REQ_UNION, 10'd1023, 10'd5);
    send_request(REQ_UNION, 10'd5, 10'd0);
    send_request(REQ_UNION, 10'd6, 10'd7);
    send_request(REQ_UNION, 10'd7, 10'd5);
    send_request(REQ_UNION, 10'h2AA, 10'h155);
    send_request(REQ_UNION, 10'h155, 10'h2AA);
    send_request(REQ_CLEAR, 10'h3FF, 10'h3FF);
    send_request(REQ_UNION, 10'd0, 10'd1023);
    send_request(REQ_UNION, 10'd1020, 10'd1021);
    send_request(REQ_UNION, 10'd1020, 10'd3);
    wait_all_results();
    // root left above a lowered count
    write_element_count(11'd16);
    send_request(REQ_UNION, 10'd3, 10'd3);
    send_request(REQ_UNION, 10'd3, 10'd16);
    send_request(REQ_UNION, 10'd15, 10'd3);
    send_request(REQ_CLEAR, 10'd0, 10'd0);
    send_request(REQ_UNION, 10'd3, 10'd3);
    wait_all_results();
    write_element_count(11'd1);
    send_request(REQ_UNION, 10'd0, 10'd0);
    send_request(REQ_UNION, 10'd0, 10'd1);
    send_request(REQ_UNION, 10'd1, 10'd0);
    wait_all_results();
    write_element_count(11'd0);
    send_request(REQ_UNION, 10'd0, 10'd0);
    send_request(REQ_CLEAR, 10'd0, 10'd0);
    wait_all_results();
    write_element_count(11'h7FF);
    send_request(REQ_UNION, 10'd1023, 10'd1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_all_results();
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      write_element_count(CNT_W'(phase_count[p]));
      for (int i = 0; i < phase_items[p]; i++) random_request();
    end

    wait_all_results();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[disjoint_set_union_engine] OK");
    end else begin
      $display("[disjoint_set_union_engine] ERROR");
    end
    $finish;
  end

endmodule
